// ===== design/itpm_pkg.sv =====
package itpm_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES = 128;

  // Fixed field widths
  localparam int unsigned BOUND_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 7;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                       operation;
    logic signed [BOUND_W-1:0]  bound_a;
    logic signed [BOUND_W-1:0]  bound_b;
    logic signed [BOUND_W-1:0]  query_point;
  } in_item_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [INDEX_W-1:0]  match_index;
    logic signed [BOUND_W-1:0]  match_low;
    logic signed [BOUND_W-1:0]  match_high;
  } out_item_t;

  // One stored interval, as held in the memory
  typedef struct packed {
    logic signed [BOUND_W-1:0] high;
    logic signed [BOUND_W-1:0] low;
  } entry_t;

endpackage

// ===== design/itpm_ram.sv =====
module itpm_ram #(
  parameter  int unsigned Width = 64,
  parameter  int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/interval_table_point_match.sv =====
// Add, table full and table empty register their result at the input transfer; a
// query scans from slot zero to a match or the last stored slot. Each result then
// moves to the output register once it can take it. One item at a time; the next input
// transfer is taken in the cycle after the result enters the output register.
// The scan reads one slot per cycle through the single read port of the interval RAM.
// Reset clears the entry count and all control; the interval RAM is not cleared.
module interval_table_point_match
  import itpm_pkg::*;
#(
  parameter int unsigned MaxEntries = MAX_ENTRIES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW  = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CountW = $clog2(MaxEntries + 1);
  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control and result registers
  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;      // stored intervals
  logic [CountW-1:0]   iss_q, iss_d;          // next slot to read
  logic                rd_vld_q, rd_vld_d;    // read data belongs to this scan
  logic                last_q, last_d;        // read data is the last stored slot
  logic [AddrW-1:0]    tag_q, tag_d;          // slot of the read data
  logic signed [BOUND_W-1:0] point_q, point_d;
  out_item_t           res_q, res_d;          // finished result awaiting the output
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Datapath
  logic                in_xfer;
  logic                is_full;
  logic signed [BOUND_W-1:0] lo_new, hi_new;
  entry_t              wr_entry;
  entry_t              rd_entry;
  logic [EntryW-1:0]   rd_raw;
  logic                mem_we, mem_re;
  logic                hit;
  logic                out_load;
  logic [INDEX_W+AddrW-1:0] wr_idx_ext, tag_idx_ext;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign is_full = (count_q == CountW'(MaxEntries));

  // Order the bounds so that low never exceeds high
  always_comb begin
    if (in_data_i.bound_b < in_data_i.bound_a) begin
      lo_new = in_data_i.bound_b;
      hi_new = in_data_i.bound_a;
    end else begin
      lo_new = in_data_i.bound_a;
      hi_new = in_data_i.bound_b;
    end
  end

  assign wr_entry = '{high: hi_new, low: lo_new};

  // Append at the first free slot in the transfer cycle itself
  assign mem_we = in_xfer && (in_data_i.operation == OP_ADD) && !is_full;
  // Keep issuing reads while stored slots remain
  assign mem_re = (state_q == ST_SCAN) && (iss_q != count_q);

  itpm_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (mem_re),
    .raddr_i (iss_q[AddrW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);
  assign hit = (point_q >= rd_entry.low) && (point_q <= rd_entry.high);

  // Report only the low bits of the slot number
  assign wr_idx_ext  = {{INDEX_W{1'b0}}, count_q[AddrW-1:0]};
  assign tag_idx_ext = {{INDEX_W{1'b0}}, tag_q};

  // Move the finished result on when the output register is free or being drained
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    last_d      = last_q;
    tag_d       = tag_q;
    point_d     = point_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.operation == OP_ADD) begin
            state_d = ST_DONE;
            if (is_full) begin
              res_d = '{status: STATUS_FULL, match_index: '0,
                        match_low: '0, match_high: '0};
            end else begin
              res_d = '{status: STATUS_ADDED,
                        match_index: wr_idx_ext[INDEX_W-1:0],
                        match_low: lo_new, match_high: hi_new};
              count_d = count_q + CountW'(1);
            end
          end else if (count_q == '0) begin
            state_d = ST_DONE;
            res_d   = '{status: STATUS_EMPTY, match_index: '0,
                        match_low: '0, match_high: '0};
          end else begin
            // Start the scan at slot zero
            state_d = ST_SCAN;
            iss_d   = '0;
            point_d = in_data_i.query_point;
          end
        end
      end

      ST_SCAN: begin
        if (rd_vld_q && hit) begin
          state_d = ST_DONE;
          res_d   = '{status: STATUS_FOUND,
                      match_index: tag_idx_ext[INDEX_W-1:0],
                      match_low: rd_entry.low, match_high: rd_entry.high};
        end else if (rd_vld_q && last_q) begin
          state_d = ST_DONE;
          res_d   = '{status: STATUS_NOT_FOUND, match_index: '0,
                      match_low: '0, match_high: '0};
        end else if (mem_re) begin
          iss_d    = iss_q + CountW'(1);
          rd_vld_d = 1'b1;
          last_d   = ((iss_q + CountW'(1)) == count_q);
          tag_d    = iss_q[AddrW-1:0];
        end
      end

      ST_DONE: begin
        if (out_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    point_q <= point_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The table never grows beyond its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxEntries))
    else $error("entry count beyond table depth");

  // Writes happen only while idle, never under a running scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("interval write outside idle");

  // A new result appears only after the done state handed it over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result presented without a finished item");

  // The count moves only with an accepted add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(mem_we))
    else $error("entry count changed without a write");

endmodule
